@@ sv/tlb_pkg.sv @@
// ----------------------------------------------------------------------------
// tlb_pkg
// shared types and codes for the fully associative tlb with lru/fifo
// replacement
// ----------------------------------------------------------------------------
package tlb_pkg;

    // request types
    localparam logic [1:0] REQ_LOOKUP = 2'd0;
    localparam logic [1:0] REQ_INSERT = 2'd1;
    localparam logic [1:0] REQ_INVAL  = 2'd2;
    localparam logic [1:0] REQ_FLUSH  = 2'd3;

    // replacement modes, anything else drops a full insert
    localparam logic [1:0] MODE_LRU  = 2'd0;
    localparam logic [1:0] MODE_FIFO = 2'd1;

    // configuration register indexes
    localparam logic CFG_ENTRIES_IN_USE = 1'b0;
    localparam logic CFG_REPLACE_MODE   = 1'b1;

    localparam logic [4:0] ENTRIES_IN_USE_RESET = 5'd16;
    localparam logic [1:0] REPLACE_MODE_RESET   = 2'd0;

    // last-use mark written by a fifo replacement
    localparam logic [31:0] STAMP_NONE = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] proc_id;
        logic [19:0] page_num;
        logic [15:0] frame_num;
    } req_t;

    typedef struct packed {
        logic        hit;
        logic [15:0] found_frame;
        logic        evicted;
    } resp_t;

    typedef struct packed {
        logic [15:0] proc_id;
        logic [19:0] page_num;
        logic [15:0] frame_num;
        logic [31:0] last_use;
        logic [31:0] ins_seq;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic rd_en;
        logic commit;
    } tlb_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_full;
    } tlb_sts_t;

endpackage

@@ sv/tlb_ctrl.sv @@
// ----------------------------------------------------------------------------
// tlb_ctrl
// sequencer: accepts a request, walks the entry memory one slot per cycle
// (flush skips the walk), then commits the update and the response
// ----------------------------------------------------------------------------
module tlb_ctrl #(
    parameter int ENTRIES = 16,
    parameter int IDX_W   = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic [1:0]        req_type,
    output logic              req_ready,
    input  tlb_pkg::tlb_sts_t sts,
    output tlb_pkg::tlb_cmd_t cmd,
    output logic [IDX_W-1:0]  scan_idx
);
    import tlb_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_COMMIT = 4'b1000
    } state_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load = 1'b1;
                    idx_next = '0;
                    // flush needs no walk over the entries
                    state_next = (req_type == REQ_FLUSH) ? ST_COMMIT : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.rd_en = 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_DRAIN:
            begin
                // last slot read is evaluated in this cycle
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (!sts.out_full)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign scan_idx  = idx_reg;

`ifndef SYNTHESIS
    a_commit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !sts.out_full)
        else $error("commit while response register is still occupied");

    a_commit_then_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> req_ready)
        else $error("controller not ready after commit");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> (scan_idx <= LAST_IDX))
        else $error("scan index beyond the last entry");

    a_load_only_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (req_ready && req_valid && !cmd.rd_en && !cmd.commit))
        else $error("request load outside idle");
`endif

endmodule

@@ sv/tlb_dp.sv @@
// ----------------------------------------------------------------------------
// tlb_dp
// entry memory, valid bits, use/insert clocks, scan accumulators for
// match / free slot / victim, and the response register
// ----------------------------------------------------------------------------
module tlb_dp #(
    parameter int ENTRIES = 16,
    parameter int IDX_W   = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tlb_pkg::req_t     req,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [4:0]        cfg_data,
    input  tlb_pkg::tlb_cmd_t cmd,
    input  logic [IDX_W-1:0]  scan_idx,
    output tlb_pkg::tlb_sts_t sts,
    output logic              resp_valid,
    input  logic              resp_ready,
    output tlb_pkg::resp_t    resp
);
    import tlb_pkg::*;

    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

    // configuration
    logic [4:0] eiu_reg;
    logic [1:0] mode_reg;

    // request and clocks
    req_t        req_reg;
    logic [31:0] use_clock_reg, use_clock_next;
    logic [31:0] ins_clock_reg, ins_clock_next;

    // entry storage
    entry_t             mem [ENTRIES];
    entry_t             rd_q;
    logic               rd_valid_q;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic               eval_en_reg;
    logic [IDX_W-1:0]   eval_idx_reg;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_widx;
    entry_t             mem_wdata;

    // scan accumulators
    logic             m_found_reg, m_found_next;
    logic [IDX_W-1:0] m_idx_reg, m_idx_next;
    logic [31:0]      m_age_reg, m_age_next;
    entry_t           m_ent_reg, m_ent_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic             v_found_reg, v_found_next;
    logic [IDX_W-1:0] v_idx_reg, v_idx_next;
    logic [31:0]      v_ua_reg, v_ua_next;
    logic [31:0]      v_ia_reg, v_ia_next;

    // response
    logic  out_valid_reg, out_valid_next;
    resp_t out_reg, out_next;

    logic [31:0] ia, ua;
    logic        match_here, victim_better;
    logic        eiu_nz, fill_ok, mode_repl;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eiu_reg  <= ENTRIES_IN_USE_RESET;
            mode_reg <= REPLACE_MODE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ENTRIES_IN_USE: eiu_reg  <= cfg_data;
                CFG_REPLACE_MODE:   mode_reg <= cfg_data[1:0];
                default:            ;
            endcase
        end
    end

    // ---------------- scan evaluation ----------------
    always_comb
    begin
        ia = ins_clock_reg - rd_q.ins_seq;
        ua = use_clock_reg - rd_q.last_use;

        match_here = rd_valid_q
            && (rd_q.proc_id == req_reg.proc_id)
            && (rd_q.page_num == req_reg.page_num)
            && ((req_reg.req_type != REQ_INVAL) || (rd_q.frame_num == req_reg.frame_num));

        if (mode_reg == MODE_LRU)
        begin
            // larger use age is older, ties go to the oldest insert
            victim_better = (ua > v_ua_reg) || ((ua == v_ua_reg) && (ia > v_ia_reg));
        end
        else
        begin
            victim_better = ia > v_ia_reg;
        end

        m_found_next    = m_found_reg;
        m_idx_next      = m_idx_reg;
        m_age_next      = m_age_reg;
        m_ent_next      = m_ent_reg;
        cnt_next        = cnt_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        v_found_next    = v_found_reg;
        v_idx_next      = v_idx_reg;
        v_ua_next       = v_ua_reg;
        v_ia_next       = v_ia_reg;

        if (cmd.load)
        begin
            m_found_next    = 1'b0;
            cnt_next        = '0;
            free_found_next = 1'b0;
            v_found_next    = 1'b0;
        end
        else if (eval_en_reg)
        begin
            if (match_here && (!m_found_reg || (ia > m_age_reg)))
            begin
                m_found_next = 1'b1;
                m_idx_next   = eval_idx_reg;
                m_age_next   = ia;
                m_ent_next   = rd_q;
            end
            if (rd_valid_q)
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (!v_found_reg || victim_better)
                begin
                    v_found_next = 1'b1;
                    v_idx_next   = eval_idx_reg;
                    v_ua_next    = ua;
                    v_ia_next    = ia;
                end
            end
            else if (!free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = eval_idx_reg;
            end
        end
    end

    // ---------------- commit ----------------
    assign eiu_nz    = (eiu_reg != 5'd0);
    assign fill_ok   = free_found_reg && (CMP_W'(cnt_reg) < CMP_W'(eiu_reg));
    assign mode_repl = (mode_reg == MODE_LRU) || (mode_reg == MODE_FIFO);

    always_comb
    begin
        use_clock_next = use_clock_reg;
        ins_clock_next = ins_clock_reg;
        valid_next     = valid_reg;
        mem_we         = 1'b0;
        mem_widx       = m_idx_reg;
        mem_wdata      = m_ent_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (resp_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
            out_next       = '0;
            case (req_reg.req_type)
                REQ_LOOKUP:
                begin
                    if (eiu_nz && m_found_reg)
                    begin
                        out_next.hit         = 1'b1;
                        out_next.found_frame = m_ent_reg.frame_num;
                        mem_we             = 1'b1;
                        mem_widx           = m_idx_reg;
                        mem_wdata          = m_ent_reg;
                        mem_wdata.last_use = use_clock_reg;
                        use_clock_next     = use_clock_reg + 32'd1;
                    end
                end
                REQ_INSERT:
                begin
                    mem_wdata.proc_id   = req_reg.proc_id;
                    mem_wdata.page_num  = req_reg.page_num;
                    mem_wdata.frame_num = req_reg.frame_num;
                    mem_wdata.last_use  = use_clock_reg;
                    mem_wdata.ins_seq   = ins_clock_reg;
                    if (eiu_nz && fill_ok)
                    begin
                        mem_we                   = 1'b1;
                        mem_widx                 = free_idx_reg;
                        valid_next[free_idx_reg] = 1'b1;
                        use_clock_next           = use_clock_reg + 32'd1;
                        ins_clock_next           = ins_clock_reg + 32'd1;
                    end
                    else if (eiu_nz && mode_repl && v_found_reg)
                    begin
                        mem_we           = 1'b1;
                        mem_widx         = v_idx_reg;
                        ins_clock_next   = ins_clock_reg + 32'd1;
                        out_next.evicted = 1'b1;
                        if (mode_reg == MODE_LRU)
                        begin
                            use_clock_next = use_clock_reg + 32'd1;
                        end
                        else
                        begin
                            mem_wdata.last_use = STAMP_NONE;
                        end
                    end
                end
                REQ_INVAL:
                begin
                    if (m_found_reg)
                    begin
                        valid_next[m_idx_reg] = 1'b0;
                    end
                end
                REQ_FLUSH:
                begin
                    valid_next = '0;
                end
                default:
                begin
                    out_next = '0;
                end
            endcase
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_clock_reg  <= '0;
            ins_clock_reg  <= '0;
            valid_reg      <= '0;
            eval_en_reg    <= 1'b0;
            m_found_reg    <= 1'b0;
            cnt_reg        <= '0;
            free_found_reg <= 1'b0;
            v_found_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            use_clock_reg  <= use_clock_next;
            ins_clock_reg  <= ins_clock_next;
            valid_reg      <= valid_next;
            eval_en_reg    <= cmd.rd_en;
            m_found_reg    <= m_found_next;
            cnt_reg        <= cnt_next;
            free_found_reg <= free_found_next;
            v_found_reg    <= v_found_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        eval_idx_reg  <= scan_idx;
        rd_valid_q    <= valid_reg[scan_idx];
        m_idx_reg     <= m_idx_next;
        m_age_reg     <= m_age_next;
        m_ent_reg     <= m_ent_next;
        free_idx_reg  <= free_idx_next;
        v_idx_reg     <= v_idx_next;
        v_ua_reg      <= v_ua_next;
        v_ia_reg      <= v_ia_next;
        out_reg       <= out_next;
    end

    // entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_widx] <= mem_wdata;
        end
        if (cmd.rd_en)
        begin
            rd_q <= mem[scan_idx];
        end
    end

    assign sts.out_full = out_valid_reg && !resp_ready;
    assign resp_valid   = out_valid_reg;
    assign resp         = out_reg;

`ifndef SYNTHESIS
    a_resp_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(resp_valid) |-> $past(cmd.commit))
        else $error("response appeared without a commit");

    a_eval_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        eval_en_reg |-> $past(cmd.rd_en))
        else $error("evaluation without a preceding memory read");

    a_ins_clock_step: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.commit |=> (ins_clock_reg == $past(ins_clock_reg)))
        else $error("insert clock moved outside a commit");

    a_use_clock_step: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.commit |=> (use_clock_reg == $past(use_clock_reg)))
        else $error("use clock moved outside a commit");
`endif

endmodule

@@ sv/tlb_lru_fifo_lookup_update_core.sv @@
// ----------------------------------------------------------------------------
// tlb_lru_fifo_lookup_update_core
// fully associative tlb tagged by process id and page, with lookup, insert,
// invalidate and flush; lru or fifo replacement once the enabled slots fill
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+-----------------------------------
//  request | req_valid / req_ready  | req  (req_type, proc_id, page_num, frame_num)
//  result  | resp_valid / resp_ready| resp (hit, found_frame, evicted)
//  config  | cfg_we (no wait)       | cfg_index, cfg_data
//
//  lookup, insert and invalidate walk the entry memory, which has a single
//  read port and is read one slot per cycle; flush skips the walk, and a new
//  request is accepted only once the previous one has committed
//  the result sits in an output register; a new request is taken while it
//  waits, and only the commit step stalls until the result is taken
//  reset clears all entries' valid bits and both clocks; no clearing pass
// ----------------------------------------------------------------------------
module tlb_lru_fifo_lookup_update_core #(
    parameter int ENTRIES = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  tlb_pkg::req_t  req,
    output logic           resp_valid,
    input  logic           resp_ready,
    output tlb_pkg::resp_t resp,
    input  logic           cfg_we,
    input  logic           cfg_index,
    input  logic [4:0]     cfg_data
);
    import tlb_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    tlb_cmd_t         cmd;
    tlb_sts_t         sts;
    logic [IDX_W-1:0] scan_idx;

    tlb_ctrl #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_type  (req.req_type),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd),
        .scan_idx  (scan_idx)
    );

    tlb_dp #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .scan_idx   (scan_idx),
        .sts        (sts),
        .resp_valid (resp_valid),
        .resp_ready (resp_ready),
        .resp       (resp)
    );

endmodule

@@ sim/tlb_lru_fifo_lookup_update_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tlb_lru_fifo_lookup_update_core_tb
// self-checking bench for the tlb core: a directed table followed by random
// phases over several slot counts and replacement modes, every result compared
// against the table's expected values or a cycle-free model of the tag store kept in the bench
// ----------------------------------------------------------------------------
module tlb_lru_fifo_lookup_update_core_tb;
    import tlb_pkg::*;

    localparam int SLOTS          = 16;
    localparam int POOL           = 24;
    localparam int PHASES         = 16;
    localparam int PHASE_ITEMS    = 120;
    localparam int DRAIN_GAP      = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ERR_PRINT_MAX  = 40;

    // modes that drop a full insert
    localparam logic [1:0] MODE_NONE = 2'd2;
    localparam logic [1:0] MODE_RSVD = 2'd3;

    typedef struct {
        logic        is_cfg;
        logic        cfg_idx;
        logic [4:0]  cfg_val;
        logic [1:0]  op;
        logic [15:0] pid;
        logic [19:0] pg;
        logic [15:0] fr;
        logic        chk;
        logic        hit;
        logic [15:0] frame;
        logic        ev;
    } dir_row_t;

    typedef struct {
        resp_t val;
        int    seq;
    } resp_rec_t;

    logic  clk;
    logic  rst_n;
    logic  req_valid;
    logic  req_ready;
    req_t  req;
    logic  resp_valid;
    logic  resp_ready;
    resp_t resp;
    logic  cfg_we;
    logic  cfg_index;
    logic  [4:0] cfg_data;

    // model of the tag store
    logic        tlb_valid [SLOTS];
    entry_t      tlb_slot [SLOTS];
    logic [31:0] use_tick;
    logic [31:0] ins_tick;
    logic [4:0]  cfg_slots;
    logic [1:0]  cfg_mode;

    resp_rec_t pending [$];
    dir_row_t  dir_tab [$];
    resp_rec_t due;

    logic [15:0] pool_pid [POOL];
    logic [19:0] pool_pg [POOL];

    logic [4:0] phase_slots [PHASES] = '{5'd16, 5'd1, 5'd2, 5'd3, 5'd0, 5'd31, 5'd4, 5'd16,
                                         5'd5, 5'd2, 5'd17, 5'd8, 5'd3, 5'd1, 5'd6, 5'd16};
    logic [1:0] phase_mode [PHASES] = '{MODE_LRU, MODE_FIFO, MODE_LRU, MODE_NONE,
                                        MODE_LRU, MODE_FIFO, MODE_RSVD, MODE_FIFO,
                                        MODE_LRU, MODE_FIFO, MODE_NONE, MODE_LRU,
                                        MODE_FIFO, MODE_LRU, MODE_FIFO, MODE_LRU};

    int idle_pct;
    int err_cnt;
    int n_req;
    int n_resp;
    int n_hit;
    int n_evict;
    int n_cfg;
    int stall_left;
    int quiet;

    tlb_lru_fifo_lookup_update_core #(
        .ENTRIES(SLOTS)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .resp_valid (resp_valid),
        .resp_ready (resp_ready),
        .resp       (resp),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [31:0] ins_age(input int i);
        return ins_tick - tlb_slot[i].ins_seq;
    endfunction

    function automatic logic [31:0] use_age(input int i);
        return use_tick - tlb_slot[i].last_use;
    endfunction

    // oldest-inserted valid slot with the tag (and frame when asked), -1 if none
    function automatic int oldest_match(input req_t r, input logic by_frame);
        int best;
        best = -1;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!tlb_valid[i] || tlb_slot[i].proc_id != r.proc_id ||
                tlb_slot[i].page_num != r.page_num)
                continue;
            if (by_frame && tlb_slot[i].frame_num != r.frame_num)
                continue;
            if (best < 0 || ins_age(i) > ins_age(best))
                best = i;
        end
        return best;
    endfunction

    function automatic void load_slot(input int i, input req_t r, input logic [31:0] stamp);
        tlb_valid[i]          = 1'b1;
        tlb_slot[i].proc_id   = r.proc_id;
        tlb_slot[i].page_num  = r.page_num;
        tlb_slot[i].frame_num = r.frame_num;
        tlb_slot[i].last_use  = stamp;
        tlb_slot[i].ins_seq   = ins_tick;
        ins_tick++;
    endfunction

    // returns 1 when a valid slot gets replaced
    function automatic logic place_entry(input req_t r);
        int lim;
        int cnt;
        int free_i;
        int victim;
        lim    = (cfg_slots > SLOTS) ? SLOTS : int'(cfg_slots);
        cnt    = 0;
        free_i = -1;
        victim = -1;
        if (lim == 0)
            return 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (tlb_valid[i])
                cnt++;
            else if (free_i < 0)
                free_i = i;
        end
        if (cnt < lim && free_i >= 0)
        begin
            load_slot(free_i, r, use_tick);
            use_tick++;
            return 1'b0;
        end
        if (cfg_mode != MODE_LRU && cfg_mode != MODE_FIFO)
            return 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!tlb_valid[i])
                continue;
            if (victim < 0)
                victim = i;
            else if (cfg_mode == MODE_LRU)
            begin
                // equal use ages fall back to insertion order
                if (use_age(i) > use_age(victim) ||
                    (use_age(i) == use_age(victim) && ins_age(i) > ins_age(victim)))
                    victim = i;
            end
            else if (ins_age(i) > ins_age(victim))
                victim = i;
        end
        if (victim < 0)
            return 1'b0;
        if (cfg_mode == MODE_LRU)
        begin
            load_slot(victim, r, use_tick);
            use_tick++;
        end
        else
            load_slot(victim, r, STAMP_NONE);
        return 1'b1;
    endfunction

    function automatic resp_t tlb_access(input req_t r);
        resp_t o;
        int    m;
        o = '0;
        case (r.req_type)
            REQ_LOOKUP:
            begin
                if (cfg_slots != 0)
                begin
                    m = oldest_match(r, 1'b0);
                    if (m >= 0)
                    begin
                        o.hit                = 1'b1;
                        o.found_frame        = tlb_slot[m].frame_num;
                        tlb_slot[m].last_use = use_tick;
                        use_tick++;
                    end
                end
            end
            REQ_INSERT:
                o.evicted = place_entry(r);
            REQ_INVAL:
            begin
                m = oldest_match(r, 1'b1);
                if (m >= 0)
                    tlb_valid[m] = 1'b0;
            end
            default:
            begin
                for (int i = 0; i < SLOTS; i++)
                    tlb_valid[i] = 1'b0;
            end
        endcase
        return o;
    endfunction

    task automatic report_mismatch(input string what, input int seq,
                                   input logic [31:0] got, input logic [31:0] want);
        if (err_cnt < ERR_PRINT_MAX)
            $display("mismatch on transaction %0d, %s: got %0h, expected %0h",
                     seq, what, got, want);
        err_cnt++;
    endtask

    // drive one request at the falling edge, keep it until taken
    task automatic send_req(input req_t r, input logic fixed, input resp_t fixed_val);
        resp_rec_t rec;
        resp_t     pred;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            req_valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        req       = r;
        req_valid = 1'b1;
        do
            @(posedge clk);
        while (req_ready !== 1'b1);
        pred     = tlb_access(r);
        rec.val  = fixed ? fixed_val : pred;
        rec.seq  = n_req;
        pending.push_back(rec);
        n_req++;
        if (pred.hit)
            n_hit++;
        if (pred.evicted)
            n_evict++;
        @(negedge clk);
    endtask

    // registers only change once the block has nothing in flight
    task automatic write_reg(input logic idx, input logic [4:0] val);
        req_valid = 1'b0;
        while (pending.size() != 0)
            @(negedge clk);
        repeat (DRAIN_GAP) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == CFG_ENTRIES_IN_USE)
            cfg_slots = val;
        else
            cfg_mode = val[1:0];
        n_cfg++;
    endtask

    // result side: random stall bursts on resp_ready
    initial
    begin
        resp_ready = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                resp_ready = 1'b0;
            end
            else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 2)
            begin
                stall_left = $urandom_range(0, 7);
                resp_ready = 1'b0;
            end
            else
                resp_ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && resp_valid === 1'b1 && resp_ready)
        begin
            n_resp++;
            if (pending.size() == 0)
                report_mismatch("result with nothing pending", -1, 32'(resp), '0);
            else
            begin
                due = pending.pop_front();
                if (resp.hit !== due.val.hit)
                    report_mismatch("hit", due.seq, 32'(resp.hit), 32'(due.val.hit));
                if (resp.found_frame !== due.val.found_frame)
                    report_mismatch("found_frame", due.seq, 32'(resp.found_frame),
                                    32'(due.val.found_frame));
                if (resp.evicted !== due.val.evicted)
                    report_mismatch("evicted", due.seq, 32'(resp.evicted),
                                    32'(due.val.evicted));
            end
        end
    end

    initial
    begin
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_ready === 1'b1) || (resp_valid === 1'b1 && resp_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("no transaction for %0d cycles, %0d results outstanding",
                 quiet, pending.size());
        $display("tlb_lru_fifo_lookup_update_core test failed");
        $finish;
    end

    initial
    begin
        req_t     r;
        resp_t    want;
        dir_row_t row;
        int       lim;
        int       tag_hi;
        int       sel;
        int       t;
        int       s;

        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_ENTRIES_IN_USE;
        cfg_data  = '0;
        idle_pct  = 20;
        err_cnt   = 0;
        n_req     = 0;
        n_resp    = 0;
        n_hit     = 0;
        n_evict   = 0;
        n_cfg     = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            tlb_valid[i] = 1'b0;
            tlb_slot[i]  = '0;
        end
        use_tick  = '0;
        ins_tick  = '0;
        cfg_slots = ENTRIES_IN_USE_RESET;
        cfg_mode  = REPLACE_MODE_RESET;

        // tag pool with the corner values up front
        pool_pid[0] = 16'h0000; pool_pg[0] = 20'h00000;
        pool_pid[1] = 16'hFFFF; pool_pg[1] = 20'hFFFFF;
        pool_pid[2] = 16'h0000; pool_pg[2] = 20'hFFFFF;
        pool_pid[3] = 16'hFFFF; pool_pg[3] = 20'h00000;
        for (int i = 4; i < POOL; i++)
        begin
            pool_pid[i] = (i % 3 == 0) ? pool_pid[i - 1] : 16'($urandom);
            pool_pg[i]  = 20'($urandom);
        end

        // is_cfg, index, value, op, pid, page, frame, chk, hit, frame, evicted
        // (index/op are fillers on the rows where they do not apply)
        dir_tab.push_back('{0, CFG_ENTRIES_IN_USE, 0, REQ_LOOKUP, 16'h0000, 20'h00000,
                            16'h0000, 1, 0, 16'h0000, 0});
        dir_tab.push_back('{0, CFG_ENTRIES_IN_USE, 0, REQ_INVAL, 16'hFFFF, 20'hFFFFF,
                            16'hFFFF, 1, 0, 16'h0000, 0});
        dir_tab.push_back('{0, CFG_ENTRIES_IN_USE, 0, REQ_INSERT, 16'hFFFF, 20'hFFFFF,
                            16'hFFFF, 1, 0, 16'h0000, 0});
        dir_tab.push_back('{0, CFG_ENTRIES_IN_USE, 0, REQ_LOOKUP, 16'hFFFF, 20'hFFFFF,
                            16'h0000, 1, 1, 16'hFFFF, 0});
        dir_tab.push_back('{0, CFG_ENTRIES_IN_USE, 0, REQ_INSERT, 16'h0000, 20'h00000,
                            16'h0000, 1, 0, 16'h0000, 0});
        dir_tab.push_back('{0, CFG_ENTRIES_IN_USE, 0, REQ_LOOKUP, 16'h0000, 20'h00000,
                            16'hFFFF, 1, 1, 16'h0000, 0});
        // duplicate tag: the older copy must keep winning
        dir_tab.push_back('{0, CFG_ENTRIES_IN_USE, 0, REQ_INSERT, 16'hFFFF, 20'hFFFFF,
                            16'h1234, 1, 0, 16'h0000, 0});
        dir_tab.push_back('{0, CFG_ENTRIES_IN_USE, 0, REQ_LOOKUP, 16'hFFFF, 20'hFFFFF,
                            16'h0000, 0, 0, 16'h0000, 0});
        dir_tab.push_back('{0, CFG_ENTRIES_IN_USE, 0, REQ_INVAL, 16'hFFFF, 20'hFFFFF,
                            16'h0000, 0, 0, 16'h0000, 0});
        dir_tab.push_back('{0, CFG_ENTRIES_IN_USE, 0, REQ_INVAL, 16'hFFFF, 20'hFFFFF,
                            16'hFFFF, 0, 0, 16'h0000, 0});
        dir_tab.push_back('{0, CFG_ENTRIES_IN_USE, 0, REQ_LOOKUP, 16'hFFFF, 20'hFFFFF,
                            16'h0000, 0, 0, 16'h0000, 0});
        dir_tab.push_back('{0, CFG_ENTRIES_IN_USE, 0, REQ_FLUSH, 16'hFFFF, 20'hFFFFF,
                            16'hFFFF, 1, 0, 16'h0000, 0});
        dir_tab.push_back('{0, CFG_ENTRIES_IN_USE, 0, REQ_LOOKUP, 16'h0000, 20'h00000,
                            16'h0000, 1, 0, 16'h0000, 0});
        // two slots: lru victim, then fifo victims
        dir_tab.push_back('{1, CFG_ENTRIES_IN_USE, 5'd2, REQ_LOOKUP, 0, 0, 0, 0, 0, 0, 0});
        dir_tab.push_back('{0, CFG_ENTRIES_IN_USE, 0, REQ_INSERT, 16'h0001, 20'h00001,
                            16'h0011, 0, 0, 16'h0000, 0});
        dir_tab.push_back('{0, CFG_ENTRIES_IN_USE, 0, REQ_INSERT, 16'h0002, 20'h00002,
                            16'h0022, 0, 0, 16'h0000, 0});
        dir_tab.push_back('{0, CFG_ENTRIES_IN_USE, 0, REQ_LOOKUP, 16'h0001, 20'h00001,
                            16'h0000, 0, 0, 16'h0000, 0});
        dir_tab.push_back('{0, CFG_ENTRIES_IN_USE, 0, REQ_INSERT, 16'h0003, 20'h00003,
                            16'h0033, 0, 0, 16'h0000, 0});
        dir_tab.push_back('{1, CFG_REPLACE_MODE, {3'b000, MODE_FIFO}, REQ_LOOKUP,
                            0, 0, 0, 0, 0, 0, 0});
        dir_tab.push_back('{0, CFG_ENTRIES_IN_USE, 0, REQ_INSERT, 16'h0004, 20'h00004,
                            16'h0044, 0, 0, 16'h0000, 0});
        dir_tab.push_back('{0, CFG_ENTRIES_IN_USE, 0, REQ_INSERT, 16'h0005, 20'h00005,
                            16'h0055, 0, 0, 16'h0000, 0});
        // both slots now carry the fifo mark, so lru sees a tie
        dir_tab.push_back('{1, CFG_REPLACE_MODE, {3'b000, MODE_LRU}, REQ_LOOKUP,
                            0, 0, 0, 0, 0, 0, 0});
        dir_tab.push_back('{0, CFG_ENTRIES_IN_USE, 0, REQ_INSERT, 16'h0006, 20'h00006,
                            16'h0066, 0, 0, 16'h0000, 0});
        dir_tab.push_back('{1, CFG_REPLACE_MODE, {3'b000, MODE_NONE}, REQ_LOOKUP,
                            0, 0, 0, 0, 0, 0, 0});
        dir_tab.push_back('{0, CFG_ENTRIES_IN_USE, 0, REQ_INSERT, 16'h0007, 20'h00007,
                            16'h0077, 1, 0, 16'h0000, 0});
        dir_tab.push_back('{1, CFG_REPLACE_MODE, {3'b000, MODE_RSVD}, REQ_LOOKUP,
                            0, 0, 0, 0, 0, 0, 0});
        dir_tab.push_back('{0, CFG_ENTRIES_IN_USE, 0, REQ_INSERT, 16'h0008, 20'h00008,
                            16'h0088, 1, 0, 16'h0000, 0});
        // table disabled
        dir_tab.push_back('{1, CFG_ENTRIES_IN_USE, 5'd0, REQ_LOOKUP, 0, 0, 0, 0, 0, 0, 0});
        dir_tab.push_back('{0, CFG_ENTRIES_IN_USE, 0, REQ_LOOKUP, 16'h0006, 20'h00006,
                            16'h0000, 1, 0, 16'h0000, 0});
        dir_tab.push_back('{0, CFG_ENTRIES_IN_USE, 0, REQ_INSERT, 16'h0009, 20'h00009,
                            16'h0099, 1, 0, 16'h0000, 0});
        // fewer slots enabled than valid
        dir_tab.push_back('{1, CFG_ENTRIES_IN_USE, 5'd1, REQ_LOOKUP, 0, 0, 0, 0, 0, 0, 0});
        dir_tab.push_back('{1, CFG_REPLACE_MODE, {3'b000, MODE_LRU}, REQ_LOOKUP,
                            0, 0, 0, 0, 0, 0, 0});
        dir_tab.push_back('{0, CFG_ENTRIES_IN_USE, 0, REQ_LOOKUP, 16'h0005, 20'h00005,
                            16'h0000, 0, 0, 16'h0000, 0});
        dir_tab.push_back('{0, CFG_ENTRIES_IN_USE, 0, REQ_INSERT, 16'h000A, 20'h0000A,
                            16'h00AA, 0, 0, 16'h0000, 0});
        dir_tab.push_back('{1, CFG_ENTRIES_IN_USE, 5'd31, REQ_LOOKUP, 0, 0, 0, 0, 0, 0, 0});
        dir_tab.push_back('{0, CFG_ENTRIES_IN_USE, 0, REQ_LOOKUP, 16'h000A, 20'h0000A,
                            16'h0000, 0, 0, 16'h0000, 0});

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_tab[k])
        begin
            row = dir_tab[k];
            if (row.is_cfg)
                write_reg(row.cfg_idx, row.cfg_val);
            else
            begin
                r.req_type         = row.op;
                r.proc_id          = row.pid;
                r.page_num         = row.pg;
                r.frame_num        = row.fr;
                want.hit           = row.hit;
                want.found_frame   = row.frame;
                want.evicted       = row.ev;
                send_req(r, row.chk, want);
            end
        end

        for (int p = 0; p < PHASES; p++)
        begin
            write_reg(CFG_ENTRIES_IN_USE, phase_slots[p]);
            write_reg(CFG_REPLACE_MODE, {3'b000, phase_mode[p]});
            idle_pct = (p == PHASES - 1) ? 0 : (p % 3) * 15;
            lim      = (cfg_slots > SLOTS) ? SLOTS : int'(cfg_slots);
            // keep the tag spread near the slot count so lookups hit
            tag_hi   = (2 * lim + 1 > POOL - 1) ? POOL - 1 : ((lim == 0) ? 3 : 2 * lim + 1);
            repeat (PHASE_ITEMS)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 45)
                    r.req_type = REQ_LOOKUP;
                else if (sel < 80)
                    r.req_type = REQ_INSERT;
                else if (sel < 96)
                    r.req_type = REQ_INVAL;
                else
                    r.req_type = REQ_FLUSH;
                if ($urandom_range(0, 9) == 0)
                begin
                    r.proc_id   = 16'($urandom);
                    r.page_num  = 20'($urandom);
                    r.frame_num = 16'($urandom);
                end
                else
                begin
                    t           = $urandom_range(0, tag_hi);
                    r.proc_id   = pool_pid[t];
                    r.page_num  = pool_pg[t];
                    r.frame_num = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 3))
                                                              : 16'($urandom);
                    // aim lookups and invalidates at live slots half the time
                    if (r.req_type != REQ_INSERT && $urandom_range(0, 1) == 1)
                    begin
                        s = $urandom_range(0, SLOTS - 1);
                        if (tlb_valid[s])
                        begin
                            r.proc_id   = tlb_slot[s].proc_id;
                            r.page_num  = tlb_slot[s].page_num;
                            r.frame_num = tlb_slot[s].frame_num;
                        end
                    end
                end
                send_req(r, 1'b0, '0);
            end
        end

        req_valid = 1'b0;
        while (pending.size() != 0)
            @(negedge clk);
        repeat (SLOTS + 8) @(negedge clk);

        $display("sent %0d requests across %0d register writes, %0d lookup hits, %0d evictions",
                 n_req, n_cfg, n_hit, n_evict);
        $display("checked %0d results, %0d mismatches", n_resp, err_cnt);
        if (err_cnt == 0)
            $display("tlb_lru_fifo_lookup_update_core test passed");
        else
            $display("tlb_lru_fifo_lookup_update_core test failed");
        $finish;
    end

endmodule
